/* rtl/core/bump_allocator_chunk_tables_core_defines.svh */
// assertion macros for the bump allocator core checker
// no dependencies
`ifndef BUMP_ALLOCATOR_CHUNK_TABLES_CORE_DEFINES_SVH
`define BUMP_ALLOCATOR_CHUNK_TABLES_CORE_DEFINES_SVH

// property checked out of reset
`define BACT_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("bact assertion failed");

// property checked also during reset
`define BACT_ASSERT_RST(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) \
    else $error("bact reset assertion failed");

`endif

/* rtl/core/bact_pkg.sv */
// types, sizes and status codes of the bump allocator core
// no dependencies
package bact_pkg;
  localparam int unsigned HEAP_BYTES  = 1048576;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned OFS_W = 20;
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned PTR_W = 21;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ZERO       = 3'd1;
  localparam logic [2:0] ST_HEAP_FULL  = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_REL_FULL   = 3'd5;

  typedef struct packed {
    logic [OFS_W-1:0]  start;
    logic [SIZE_W-1:0] size;
  } ent_t;

  typedef struct packed {
    logic load;
    logic alloc;
    logic srch_rd;
    logic srch_step;
    logic set_nf;
    logic set_rf;
    logic ins_rd;
    logic ins_shift;
    logic ins_put;
    logic rem_rd;
    logic rem_shift;
    logic rem_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic srch_done;
    logic hit;
    logic rel_full;
    logic ins_top;
    logic ins_move;
    logic rem_more;
    logic out_busy;
  } sts_t;
endpackage

/* rtl/core/bact_in_if.sv */
// request channel and result channel interfaces
// depends on bact_pkg
interface bact_in_if;
  import bact_pkg::*;
  logic                valid;
  logic                ready;
  logic                action;
  logic [SIZE_W-1:0]   alloc_size;
  logic [OFS_W-1:0]    free_offset;
  modport source (output valid, action, alloc_size, free_offset, input ready);
  modport sink (input valid, action, alloc_size, free_offset, output ready);
endinterface

interface bact_out_if;
  import bact_pkg::*;
  logic             valid;
  logic             ready;
  logic [OFS_W-1:0] chunk_offset;
  logic [2:0]       status;
  modport source (output valid, chunk_offset, status, input ready);
  modport sink (input valid, chunk_offset, status, output ready);
endinterface

/* rtl/core/bact_ctrl.sv */
// sequencer for allocate and free items
// depends on bact_pkg
module bact_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_fire,
  input  bact_pkg::sts_t  sts,
  output logic            idle,
  output bact_pkg::cmd_t  cmd
);
  import bact_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_SRCH = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_INS  = 4'd4;
  localparam logic [3:0] S_ICMP = 4'd5;
  localparam logic [3:0] S_REM  = 4'd6;
  localparam logic [3:0] S_RWR  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_free) begin
          state_nxt = S_SRCH;
        end else begin
          cmd.alloc = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_SRCH: begin
        if (sts.srch_done) begin
          cmd.set_nf = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_step = 1'b1;
        if (!sts.hit) begin
          state_nxt = S_SRCH;
        end else if (sts.rel_full) begin
          cmd.set_rf = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        if (sts.ins_top) begin
          cmd.ins_put = 1'b1;
          state_nxt = S_REM;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        if (sts.ins_move) begin
          cmd.ins_shift = 1'b1;
          state_nxt = S_INS;
        end else begin
          cmd.ins_put = 1'b1;
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        if (sts.rem_more) begin
          cmd.rem_rd = 1'b1;
          state_nxt = S_RWR;
        end else begin
          cmd.rem_fin = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_RWR: begin
        cmd.rem_shift = 1'b1;
        state_nxt = S_REM;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* rtl/core/bact_dp.sv */
// bump pointer, chunk tables, search and shift datapath, result register
// depends on bact_pkg
module bact_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bact_pkg::cmd_t          cmd,
  output bact_pkg::sts_t          sts,
  input  logic                    in_action,
  input  logic [bact_pkg::SIZE_W-1:0] in_alloc_size,
  input  logic [bact_pkg::OFS_W-1:0]  in_free_offset,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [bact_pkg::OFS_W-1:0]  out_chunk_offset,
  output logic [2:0]              out_status
);
  import bact_pkg::*;

  localparam logic [PTR_W:0] HEAP_W = (PTR_W+1)'(HEAP_BYTES);
  localparam logic [CNT_W-1:0] DEPTH_W = CNT_W'(TABLE_DEPTH);

  ent_t used_mem [TABLE_DEPTH];
  ent_t rel_mem [TABLE_DEPTH];
  ent_t used_q_r, rel_q_r, ent_r;

  logic [PTR_W-1:0]  bump_r;
  logic [CNT_W-1:0]  ucount_r, rcount_r, lo_r, hi_r, mid;
  logic [IDX_W-1:0]  mid_r, idx_r, ins_r;
  logic              action_r;
  logic [SIZE_W-1:0] size_r;
  logic [OFS_W-1:0]  key_r, res_r;
  logic [2:0]        st_r, alloc_st;
  logic              out_valid_r;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    priority if (size_r == '0) alloc_st = ST_ZERO;
    else if ({1'b0, size_r} > HEAP_W - {1'b0, bump_r}) alloc_st = ST_HEAP_FULL;
    else if (ucount_r >= DEPTH_W) alloc_st = ST_TABLE_FULL;
    else alloc_st = ST_OK;
  end

  always_comb begin
    sts.is_free   = action_r;
    sts.srch_done = (lo_r >= hi_r);
    sts.hit       = (used_q_r.start == key_r);
    sts.rel_full  = (rcount_r >= DEPTH_W);
    sts.ins_top   = (ins_r == '0);
    sts.ins_move  = (rel_q_r.start > ent_r.start);
    sts.rem_more  = ({1'b0, idx_r} + CNT_W'(1)) < ucount_r;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // table memories
  always_ff @(posedge clk) begin
    if (cmd.alloc && alloc_st == ST_OK) begin
      used_mem[ucount_r[IDX_W-1:0]] <= '{start: bump_r[OFS_W-1:0], size: size_r};
    end else if (cmd.rem_shift) begin
      used_mem[idx_r] <= used_q_r;
    end
    if (cmd.srch_rd) begin
      used_q_r <= used_mem[mid[IDX_W-1:0]];
    end else if (cmd.rem_rd) begin
      used_q_r <= used_mem[idx_r + IDX_W'(1)];
    end
    if (cmd.ins_shift) begin
      rel_mem[ins_r] <= rel_q_r;
    end else if (cmd.ins_put) begin
      rel_mem[ins_r] <= ent_r;
    end
    if (cmd.ins_rd) begin
      rel_q_r <= rel_mem[ins_r - IDX_W'(1)];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      size_r   <= in_alloc_size;
      key_r    <= in_free_offset;
      st_r     <= ST_OK;
      res_r    <= in_action ? in_free_offset : '0;
      lo_r     <= '0;
      hi_r     <= ucount_r;
    end
    if (cmd.alloc) begin
      st_r <= alloc_st;
      if (alloc_st == ST_OK) begin
        res_r <= bump_r[OFS_W-1:0];
      end
    end
    if (cmd.set_nf) st_r <= ST_NOT_FOUND;
    if (cmd.set_rf) st_r <= ST_REL_FULL;
    if (cmd.srch_rd) mid_r <= mid[IDX_W-1:0];
    if (cmd.srch_step) begin
      ent_r <= used_q_r;
      idx_r <= mid_r;
      ins_r <= rcount_r[IDX_W-1:0];
      if (used_q_r.start < key_r) begin
        lo_r <= {1'b0, mid_r} + CNT_W'(1);
      end else begin
        hi_r <= {1'b0, mid_r};
      end
    end
    if (cmd.ins_shift) ins_r <= ins_r - IDX_W'(1);
    if (cmd.rem_shift) idx_r <= idx_r + IDX_W'(1);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bump_r      <= '0;
      ucount_r    <= '0;
      rcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.alloc && alloc_st == ST_OK) begin
        bump_r   <= bump_r + size_r;
        ucount_r <= ucount_r + CNT_W'(1);
      end
      if (cmd.rem_fin) ucount_r <= ucount_r - CNT_W'(1);
      if (cmd.ins_put) rcount_r <= rcount_r + CNT_W'(1);
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_chunk_offset <= res_r;
      out_status       <= st_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule

/* rtl/core/bump_allocator_chunk_tables_core.sv */
// top level of the bump allocator core: sequencer plus datapath
// depends on bact_pkg, bact_in_if, bact_out_if, bact_ctrl, bact_dp
//
//  channel | dir | signals
//  in_ch   | in  | valid ready action alloc_size free_offset
//  out_ch  | out | valid ready chunk_offset status
//
// allocate: the decode state writes the chunk, the output state the result
// free: binary search of up to 11 probes, then released entries moved up
//   and used entries moved down, single-port table memories set the pace
// reset clears bump pointer and counts, tables need no clearing
// one item at a time; a result waits in the output register while the next
//   item is accepted, the sequencer holds only when that register is still full
module bump_allocator_chunk_tables_core (
  input logic clk,
  input logic rst_n,
  bact_in_if.sink    in_ch,
  bact_out_if.source out_ch
);
  import bact_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;
  logic in_fire;

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && idle;

  bact_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  bact_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_ch.action),
    .in_alloc_size    (in_ch.alloc_size),
    .in_free_offset   (in_ch.free_offset),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_chunk_offset (out_ch.chunk_offset),
    .out_status       (out_ch.status)
  );
endmodule

/* rtl/core/bact_chk.sv */
// port-level checker for the bump allocator core, bound to the top level
// depends on bump_allocator_chunk_tables_core_defines.svh
`include "bump_allocator_chunk_tables_core_defines.svh"

module bact_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_status
);
  `BACT_ASSERT_RST(a_rst_no_out, clk, !rst_n |=> !out_valid)
  `BACT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `BACT_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `BACT_ASSERT(a_status_range, clk, rst_n, out_valid |-> out_status <= 3'd5)
endmodule

bind bump_allocator_chunk_tables_core bact_chk u_bact_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status)
);

/* tb/bump_allocator_chunk_tables_core_tb.sv */
// self-checking testbench for bump_allocator_chunk_tables_core: a predictor of the bump
// pointer and both sorted chunk tables checks each result, with random gaps and stalls
// depends on bact_pkg, bact_in_if, bact_out_if and the core
module bump_allocator_chunk_tables_core_tb;
  import bact_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam bit ACT_ALLOC = 1'b0;
  localparam bit ACT_FREE  = 1'b1;

  typedef struct {
    logic [OFS_W-1:0] chunk_offset;
    logic [2:0]       status;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;

  bact_in_if  in_ch ();
  bact_out_if out_ch ();

  bump_allocator_chunk_tables_core DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // own copy of the heap bookkeeping
  logic [PTR_W-1:0]  heap_top;
  logic [OFS_W-1:0]  live_start [TABLE_DEPTH];
  logic [SIZE_W-1:0] live_size  [TABLE_DEPTH];
  int unsigned       live_cnt;
  logic [OFS_W-1:0]  dead_start [TABLE_DEPTH];
  logic [SIZE_W-1:0] dead_size  [TABLE_DEPTH];
  int unsigned       dead_cnt;
  heap_result_t      pending_results[$];

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL bump_allocator_chunk_tables_core");
      $finish;
    end
  end

  task automatic predict_heap(input bit act, input logic [SIZE_W-1:0] sz,
                              input logic [OFS_W-1:0] ofs);
    heap_result_t r;
    int pos;
    int i;
    r.chunk_offset = '0;
    r.status = ST_OK;
    pos = -1;
    if (act == ACT_ALLOC) begin
      if (sz == 0) begin
        r.status = ST_ZERO;
      end else if (sz > HEAP_BYTES - heap_top) begin
        r.status = ST_HEAP_FULL;
      end else if (live_cnt >= TABLE_DEPTH) begin
        r.status = ST_TABLE_FULL;
      end else begin
        r.chunk_offset = heap_top[OFS_W-1:0];
        i = live_cnt;
        while (i > 0 && live_start[i-1] > heap_top[OFS_W-1:0]) begin
          live_start[i] = live_start[i-1];
          live_size[i] = live_size[i-1];
          i--;
        end
        live_start[i] = heap_top[OFS_W-1:0];
        live_size[i] = sz;
        live_cnt++;
        heap_top = heap_top + sz;
      end
    end else begin
      r.chunk_offset = ofs;
      for (i = 0; i < live_cnt; i++)
        if (live_start[i] == ofs) pos = i;
      if (pos < 0) begin
        r.status = ST_NOT_FOUND;
      end else if (dead_cnt >= TABLE_DEPTH) begin
        r.status = ST_REL_FULL;
      end else begin
        i = dead_cnt;
        while (i > 0 && dead_start[i-1] > live_start[pos]) begin
          dead_start[i] = dead_start[i-1];
          dead_size[i] = dead_size[i-1];
          i--;
        end
        dead_start[i] = live_start[pos];
        dead_size[i] = live_size[pos];
        dead_cnt++;
        for (i = pos; i + 1 < live_cnt; i++) begin
          live_start[i] = live_start[i+1];
          live_size[i] = live_size[i+1];
        end
        live_cnt--;
      end
    end
    pending_results.push_back(r);
  endtask

  task automatic send_item(input bit act, input logic [SIZE_W-1:0] sz,
                           input logic [OFS_W-1:0] ofs);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.alloc_size <= sz;
    in_ch.free_offset <= ofs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_heap(act, sz, ofs);
  endtask

  task automatic alloc_chunk(input logic [SIZE_W-1:0] sz);
    send_item(ACT_ALLOC, sz, OFS_W'($urandom));
  endtask

  task automatic free_chunk(input logic [OFS_W-1:0] ofs);
    send_item(ACT_FREE, SIZE_W'($urandom), ofs);
  endtask

  task automatic test_directed();
    alloc_chunk('0);
    alloc_chunk(1);
    free_chunk('0);
    free_chunk('0);
    alloc_chunk({SIZE_W{1'b1}});
    alloc_chunk(SIZE_W'(HEAP_BYTES));
    alloc_chunk(100);
    alloc_chunk(5);
    alloc_chunk(64);
    free_chunk(live_start[1]);
    free_chunk({OFS_W{1'b1}});
    free_chunk(OFS_W'(3));
    alloc_chunk(4096);
    free_chunk(live_start[live_cnt-1]);
    free_chunk(live_start[0]);
    alloc_chunk(1);
    send_item(ACT_ALLOC, '0, {OFS_W{1'b1}});
    send_item(ACT_FREE, {SIZE_W{1'b1}}, dead_start[0]);
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned k;
    int unsigned pick;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99, 0);
      if (pick < 45) alloc_chunk(SIZE_W'($urandom_range(64, 1)));
      else if (pick < 52) alloc_chunk(SIZE_W'($urandom_range(4096, 65)));
      else if (pick < 55) alloc_chunk(SIZE_W'($urandom));
      else if (pick < 57) alloc_chunk('0);
      else if (pick < 85 && live_cnt > 0) free_chunk(live_start[$urandom_range(live_cnt-1, 0)]);
      else if (pick < 92 && dead_cnt > 0) free_chunk(dead_start[$urandom_range(dead_cnt-1, 0)]);
      else free_chunk(OFS_W'($urandom));
    end
  endtask

  task automatic test_heap_exhaust();
    alloc_chunk(SIZE_W'(HEAP_BYTES - heap_top));
    alloc_chunk(1);
    if (live_cnt > 0) free_chunk(live_start[live_cnt-1]);
  endtask

  // receiver stalls in modes that change now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(63, 0) == 0) stall_mode = $urandom_range(2, 0);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(1, 0);
        default: out_ch.ready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    heap_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected item: expected none, got offset %h status %0d",
                 $time, out_ch.chunk_offset, out_ch.status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.chunk_offset !== e.chunk_offset) begin
          $display("%0t chunk_offset: expected %h, got %h", $time, e.chunk_offset,
                   out_ch.chunk_offset);
          errors++;
        end
        if (out_ch.status !== e.status) begin
          $display("%0t status: expected %0d, got %0d", $time, e.status, out_ch.status);
          errors++;
        end
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.action <= 1'b0;
    in_ch.alloc_size <= '0;
    in_ch.free_offset <= '0;
    heap_top = '0;
    live_cnt = 0;
    dead_cnt = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(560);
    test_heap_exhaust();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("PASS bump_allocator_chunk_tables_core");
    end else begin
      $display("FAIL bump_allocator_chunk_tables_core");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bact_pkg.sv
rtl/core/bact_in_if.sv
rtl/core/bact_ctrl.sv
rtl/core/bact_dp.sv
rtl/core/bump_allocator_chunk_tables_core.sv
rtl/core/bact_chk.sv
tb/bump_allocator_chunk_tables_core_tb.sv
